>>> src/pip_pkg.sv
// Shared types, widths, codes and the sequencer microprogram of the point-in-polygon core.
package pip_pkg;

   localparam int DEF_MAX_VERTICES = 16;

   localparam int CRD_W      = 16;
   localparam int DIF_W      = CRD_W + 1;
   localparam int XF_W       = CRD_W + 2;
   localparam int MA_W       = CRD_W + 3;
   localparam int MB_W       = DIF_W;
   localparam int PRD_W      = MA_W + MB_W;
   localparam int CRS_W      = PRD_W + 1;
   localparam int VIDX_W     = 4;
   localparam int VCNT_W     = 5;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 5;
   localparam int STEP_W     = 5;

   localparam logic [CSR_IDX_W-1:0] CSR_VERTEX_COUNT = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IS_OPEN      = 1'd1;

   localparam logic OPERATION_LOAD  = 1'b0;
   localparam logic OPERATION_QUERY = 1'b1;

   localparam logic signed [CRD_W-1:0] CRD_MAX = {1'b0, {(CRD_W-1){1'b1}}};
   localparam logic signed [CRD_W-1:0] CRD_MIN = {1'b1, {(CRD_W-1){1'b0}}};

   typedef logic [STEP_W-1:0] step_type;

   localparam step_type ST_INIT  = 5'd0;
   localparam step_type ST_XRD   = 5'd1;
   localparam step_type ST_XUPD  = 5'd2;
   localparam step_type ST_FAR   = 5'd3;
   localparam step_type ST_LOOP  = 5'd4;
   localparam step_type ST_D1    = 5'd5;
   localparam step_type ST_SRD   = 5'd6;
   localparam step_type ST_SCHK  = 5'd7;
   localparam step_type ST_RUN   = 5'd8;
   localparam step_type ST_SGN   = 5'd9;
   localparam step_type ST_MULA  = 5'd10;
   localparam step_type ST_MULB  = 5'd11;
   localparam step_type ST_MULC  = 5'd12;
   localparam step_type ST_DIFF  = 5'd13;
   localparam step_type ST_CROSS = 5'd14;
   localparam step_type ST_ADV   = 5'd15;
   localparam step_type ST_PAR   = 5'd16;
   localparam step_type ST_ONE   = 5'd17;
   localparam step_type ST_ZERO  = 5'd18;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_INIT,
      OP_XUPD,
      OP_FAR,
      OP_D1,
      OP_SKIP,
      OP_MUL_A,
      OP_MUL_B,
      OP_MUL_C,
      OP_DIFF,
      OP_CROSS,
      OP_ADV,
      OP_RES_PAR,
      OP_RES_ONE,
      OP_RES_ZERO
   } op_type;

   typedef enum logic [1:0] {
      RD_PTR,
      RD_AI,
      RD_AN
   } rd_type;

   typedef enum logic [3:0] {
      C_NEVER,
      C_ALWAYS,
      C_STOP,
      C_MORE,
      C_WALK_DONE,
      C_ROW_HIT,
      C_RUN_HIT,
      C_NO_CHANGE,
      C_CROSS_ZERO
   } cond_type;

   typedef struct packed {
      op_type   op;
      rd_type   rd;
      cond_type cond;
      step_type target;
      logic     last;
   } cw_type;

   typedef struct packed {
      logic stop;
      logic last_x;
      logic walk_done;
      logic row_hit;
      logic run_hit;
      logic no_change;
      logic cross_zero;
   } flags_type;

   localparam cw_type IDLE_WORD = '{op: OP_NONE, rd: RD_PTR, cond: C_NEVER,
                                    target: ST_INIT, last: 1'b0};

   function automatic cw_type micro_word(input step_type s);
      cw_type w;
      w = IDLE_WORD;
      unique case (s)
         ST_INIT:  w = '{op: OP_INIT, rd: RD_PTR, cond: C_STOP, target: ST_ZERO, last: 1'b0};
         ST_XRD:   w = '{op: OP_NONE, rd: RD_PTR, cond: C_NEVER, target: ST_INIT, last: 1'b0};
         ST_XUPD:  w = '{op: OP_XUPD, rd: RD_PTR, cond: C_MORE, target: ST_XRD, last: 1'b0};
         ST_FAR:   w = '{op: OP_FAR, rd: RD_PTR, cond: C_NEVER, target: ST_INIT, last: 1'b0};
         ST_LOOP:  w = '{op: OP_NONE, rd: RD_AI, cond: C_WALK_DONE, target: ST_PAR,
                         last: 1'b0};
         ST_D1:    w = '{op: OP_D1, rd: RD_PTR, cond: C_ROW_HIT, target: ST_ADV, last: 1'b0};
         ST_SRD:   w = '{op: OP_NONE, rd: RD_AN, cond: C_NEVER, target: ST_INIT, last: 1'b0};
         ST_SCHK:  w = '{op: OP_SKIP, rd: RD_PTR, cond: C_ROW_HIT, target: ST_SRD, last: 1'b0};
         ST_RUN:   w = '{op: OP_NONE, rd: RD_PTR, cond: C_RUN_HIT, target: ST_ONE, last: 1'b0};
         ST_SGN:   w = '{op: OP_NONE, rd: RD_PTR, cond: C_NO_CHANGE, target: ST_ADV,
                         last: 1'b0};
         ST_MULA:  w = '{op: OP_MUL_A, rd: RD_PTR, cond: C_NEVER, target: ST_INIT, last: 1'b0};
         ST_MULB:  w = '{op: OP_MUL_B, rd: RD_PTR, cond: C_NEVER, target: ST_INIT, last: 1'b0};
         ST_MULC:  w = '{op: OP_MUL_C, rd: RD_PTR, cond: C_NEVER, target: ST_INIT, last: 1'b0};
         ST_DIFF:  w = '{op: OP_DIFF, rd: RD_PTR, cond: C_NEVER, target: ST_INIT, last: 1'b0};
         ST_CROSS: w = '{op: OP_CROSS, rd: RD_PTR, cond: C_CROSS_ZERO, target: ST_ONE,
                         last: 1'b0};
         ST_ADV:   w = '{op: OP_ADV, rd: RD_PTR, cond: C_ALWAYS, target: ST_LOOP, last: 1'b0};
         ST_PAR:   w = '{op: OP_RES_PAR, rd: RD_PTR, cond: C_NEVER, target: ST_INIT,
                         last: 1'b1};
         ST_ONE:   w = '{op: OP_RES_ONE, rd: RD_PTR, cond: C_NEVER, target: ST_INIT,
                         last: 1'b1};
         ST_ZERO:  w = '{op: OP_RES_ZERO, rd: RD_PTR, cond: C_NEVER, target: ST_INIT,
                         last: 1'b1};
         default:  w = IDLE_WORD;
      endcase
      return w;
   endfunction

endpackage

>>> src/pip_seq.sv
// Microprogram sequencer: step counter, control store lookup and conditional jumps.
module pip_seq import pip_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      go,
   input  flags_type flags,
   output cw_type    cw,
   output logic      busy
);

   step_type step_ff, step_in;
   logic     busy_ff, busy_in;
   logic     taken;

   always_comb begin
      cw = micro_word(step_ff);
      if (!busy_ff) begin
         cw = IDLE_WORD;
      end
      case (cw.cond)
         C_ALWAYS:     taken = 1'b1;
         C_STOP:       taken = flags.stop;
         C_MORE:       taken = !flags.last_x;
         C_WALK_DONE:  taken = flags.walk_done;
         C_ROW_HIT:    taken = flags.row_hit;
         C_RUN_HIT:    taken = flags.run_hit;
         C_NO_CHANGE:  taken = flags.no_change;
         C_CROSS_ZERO: taken = flags.cross_zero;
         default:      taken = 1'b0;
      endcase
      step_in = taken ? cw.target : step_ff + STEP_W'(1);
      busy_in = busy_ff;
      if (go) begin
         busy_in = 1'b1;
         step_in = ST_INIT;
      end else if (busy_ff && cw.last) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= ST_INIT;
         busy_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         busy_ff <= busy_in;
      end
   end

   assign busy = busy_ff;

endmodule

>>> src/pip_dpath.sv
// Datapath of the point-in-polygon core: vertex memory, extent, edge walk and cross products.
module pip_dpath import pip_pkg::*; #(
   parameter int MAX_VERTICES = DEF_MAX_VERTICES,
   parameter int AW = $clog2(MAX_VERTICES),
   parameter int NW = $clog2(MAX_VERTICES + 1)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    load_we,
   input  logic [AW-1:0]           load_addr,
   input  logic                    query_go,
   input  logic signed [CRD_W-1:0] in_x,
   input  logic signed [CRD_W-1:0] in_y,
   input  logic [NW-1:0]           n_cnt,
   input  logic                    open_mode,
   input  cw_type                  cw,
   output flags_type               flags,
   output logic                    rsp_strobe,
   output logic                    rsp_inside
);

   localparam int IW = $clog2(2 * MAX_VERTICES + 1);

   logic signed [CRD_W-1:0] vx_mem [MAX_VERTICES];
   logic signed [CRD_W-1:0] vy_mem [MAX_VERTICES];

   logic [AW-1:0]           rd_addr;
   logic signed [CRD_W-1:0] rd_x_ff, rd_y_ff;
   logic signed [CRD_W-1:0] px_ff, py_ff;
   logic signed [CRD_W-1:0] xmin_ff, xmax_ff;
   logic signed [XF_W-1:0]  xfar_ff;
   logic [AW-1:0]           ptr_ff, ai_ff, an_ff;
   logic [IW-1:0]           i_ff;
   logic signed [CRD_W-1:0] x1_ff, y1_ff, x2_ff, y2_ff, runx_ff;
   logic                    skipped_ff, d1neg_ff, parity_ff;
   logic signed [PRD_W-1:0] ma_ff, mb_ff, mc_ff;
   logic signed [CRS_W-1:0] c1_ff, c2_ff;
   logic                    strobe_ff, inside_ff;

   logic [AW-1:0]           an_next, first_next;
   logic signed [DIF_W-1:0] dpy, dpx, dx21, dy21, run_a, run_b;
   logic signed [MA_W-1:0]  dxf, mul_a;
   logic signed [MB_W-1:0]  mul_b;
   logic signed [PRD_W-1:0] prod;

   always_comb begin
      unique case (cw.rd)
         RD_AI:   rd_addr = ai_ff;
         RD_AN:   rd_addr = an_ff;
         default: rd_addr = ptr_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (load_we) begin
         vx_mem[load_addr] <= in_x;
         vy_mem[load_addr] <= in_y;
      end
      rd_x_ff <= vx_mem[rd_addr];
      rd_y_ff <= vy_mem[rd_addr];
   end

   assign an_next    = (NW'(an_ff) + NW'(1) == n_cnt) ? '0 : an_ff + AW'(1);
   assign first_next = (n_cnt == NW'(1)) ? '0 : AW'(1);

   assign dpy   = DIF_W'(py_ff) - DIF_W'(y1_ff);
   assign dpx   = DIF_W'(px_ff) - DIF_W'(x1_ff);
   assign dx21  = DIF_W'(x2_ff) - DIF_W'(x1_ff);
   assign dy21  = DIF_W'(y2_ff) - DIF_W'(y1_ff);
   assign dxf   = MA_W'(xfar_ff) - MA_W'(x1_ff);
   assign run_a = DIF_W'(runx_ff) - DIF_W'(px_ff);
   assign run_b = DIF_W'(x1_ff) - DIF_W'(px_ff);

   always_comb begin
      mul_a = MA_W'(dpy);
      mul_b = dx21;
      if (cw.op == OP_MUL_B) begin
         mul_a = MA_W'(dpx);
         mul_b = dy21;
      end else if (cw.op == OP_MUL_C) begin
         mul_a = dxf;
         mul_b = dy21;
      end
   end

   assign prod = PRD_W'(mul_a) * PRD_W'(mul_b);

   always_comb begin
      flags.stop       = open_mode || (n_cnt == '0);
      flags.last_x     = (NW'(ptr_ff) + NW'(1) == n_cnt);
      flags.walk_done  = (i_ff >= IW'(n_cnt));
      flags.row_hit    = (rd_y_ff == py_ff);
      flags.run_hit    = skipped_ff && ((run_a == '0) || (run_b == '0) ||
                                        (run_a[DIF_W-1] != run_b[DIF_W-1]));
      flags.no_change  = (d1neg_ff == (y2_ff < py_ff));
      flags.cross_zero = (c1_ff == '0) || (c2_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (query_go) begin
         px_ff <= in_x;
         py_ff <= in_y;
      end
      unique case (cw.op)
         OP_INIT: begin
            ptr_ff    <= '0;
            xmin_ff   <= CRD_MAX;
            xmax_ff   <= CRD_MIN;
            parity_ff <= 1'b0;
         end
         OP_XUPD: begin
            if (rd_x_ff < xmin_ff) begin
               xmin_ff <= rd_x_ff;
            end
            if (rd_x_ff > xmax_ff) begin
               xmax_ff <= rd_x_ff;
            end
            ptr_ff <= ptr_ff + AW'(1);
         end
         OP_FAR: begin
            xfar_ff <= XF_W'(xmax_ff) + XF_W'(xmax_ff) + XF_W'(2) - XF_W'(xmin_ff);
            ai_ff   <= '0;
            an_ff   <= first_next;
            i_ff    <= '0;
         end
         OP_D1: begin
            x1_ff      <= rd_x_ff;
            y1_ff      <= rd_y_ff;
            d1neg_ff   <= (rd_y_ff < py_ff);
            skipped_ff <= 1'b0;
         end
         OP_SKIP: begin
            x2_ff <= rd_x_ff;
            y2_ff <= rd_y_ff;
            if (rd_y_ff == py_ff) begin
               if (!skipped_ff) begin
                  runx_ff <= rd_x_ff;
               end
               skipped_ff <= 1'b1;
               x1_ff      <= rd_x_ff;
               y1_ff      <= rd_y_ff;
               i_ff       <= i_ff + IW'(1);
               ai_ff      <= an_ff;
               an_ff      <= an_next;
            end
         end
         OP_MUL_A: ma_ff <= prod;
         OP_MUL_B: mb_ff <= prod;
         OP_MUL_C: mc_ff <= prod;
         OP_DIFF: begin
            c1_ff <= CRS_W'(mb_ff) - CRS_W'(ma_ff);
            c2_ff <= CRS_W'(mc_ff) - CRS_W'(ma_ff);
         end
         OP_CROSS: begin
            if (!flags.cross_zero) begin
               parity_ff <= parity_ff ^ (c1_ff[CRS_W-1] != c2_ff[CRS_W-1]);
            end
         end
         OP_ADV: begin
            i_ff  <= i_ff + IW'(1);
            ai_ff <= an_ff;
            an_ff <= an_next;
         end
         OP_RES_PAR:  inside_ff <= parity_ff;
         OP_RES_ONE:  inside_ff <= 1'b1;
         OP_RES_ZERO: inside_ff <= 1'b0;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= (cw.op == OP_RES_PAR) || (cw.op == OP_RES_ONE) ||
                      (cw.op == OP_RES_ZERO);
      end
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_inside = inside_ff;

endmodule

>>> src/point_in_polygon_test_core.sv
// Top level of the point-in-polygon core: command port, register file and the two engines.
//
// Usage: a word is taken on the req_ ports at a clock edge where start is high and busy
// is low. A load word (req_operation = 0) writes one vertex slot at once and gives no
// response; busy stays low, so loads may come every cycle. A query word
// (req_operation = 1) raises busy and walks the vertex store under a microprogram.
// Its answer appears on rsp_inside_res for one cycle with rsp_strobe high; busy falls
// at the same edge, so the next word may be offered in that cycle.
// A query on an open or empty shape is answered outside without a walk; otherwise an
// extent pass over the n vertices in use and the walk setup come first, then the walk
// reads each vertex, passes over one on the query row, else skips any run of on-row
// vertices after it and forms cross products where the edge straddles the row; the
// single read port of the vertex memory and the shared multiplier set the length of a query.
// The csr_ port writes the vertex count and the open flag; write it only while idle.
// Reset clears busy, the response strobe and both registers; vertex slots hold
// garbage until loaded. The receiver cannot stall: each response is shown once.
module point_in_polygon_test_core import pip_pkg::*; #(
   parameter int MAX_VERTICES = DEF_MAX_VERTICES
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic                         req_operation,
   input  logic [VIDX_W-1:0]            req_vertex_index,
   input  logic signed [CRD_W-1:0]      req_coord_x,
   input  logic signed [CRD_W-1:0]      req_coord_y,
   output logic                         rsp_strobe,
   output logic                         rsp_inside_res,
   input  logic                         csr_wen,
   input  logic [CSR_IDX_W-1:0]         csr_index,
   input  logic [CSR_DATA_W-1:0]        csr_wdata
);

   localparam int AW = $clog2(MAX_VERTICES);
   localparam int NW = $clog2(MAX_VERTICES + 1);

   logic [NW-1:0] count_ff;
   logic          open_ff;
   logic          accept, load_we, query_go;
   cw_type        cw;
   flags_type     flags;

   assign accept   = start && !busy;
   assign load_we  = accept && (req_operation == OPERATION_LOAD) &&
                     (32'(req_vertex_index) < 32'(MAX_VERTICES));
   assign query_go = accept && (req_operation == OPERATION_QUERY);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         open_ff  <= 1'b0;
      end else if (csr_wen) begin
         unique case (csr_index)
            CSR_VERTEX_COUNT: begin
               if (32'(csr_wdata[VCNT_W-1:0]) > 32'(MAX_VERTICES)) begin
                  count_ff <= NW'(MAX_VERTICES);
               end else begin
                  count_ff <= NW'(csr_wdata[VCNT_W-1:0]);
               end
            end
            CSR_IS_OPEN: open_ff <= csr_wdata[0];
         endcase
      end
   end

   pip_seq u_seq (
      .clock (clock),
      .reset (reset),
      .go    (query_go),
      .flags (flags),
      .cw    (cw),
      .busy  (busy)
   );

   pip_dpath #(
      .MAX_VERTICES (MAX_VERTICES),
      .AW           (AW),
      .NW           (NW)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .load_we    (load_we),
      .load_addr  (AW'(req_vertex_index)),
      .query_go   (query_go),
      .in_x       (req_coord_x),
      .in_y       (req_coord_y),
      .n_cnt      (count_ff),
      .open_mode  (open_ff),
      .cw         (cw),
      .flags      (flags),
      .rsp_strobe (rsp_strobe),
      .rsp_inside (rsp_inside_res)
   );

endmodule

>>> tb/sv/point_in_polygon_test_core_tb.sv
// Self-checking testbench for the point-in-polygon core: vertex loads and point queries.
`timescale 1ns / 1ps

module point_in_polygon_test_core_tb import pip_pkg::*;;

   localparam int MAX_SLOTS   = DEF_MAX_VERTICES;
   localparam int STALL_LIMIT = 4000;
   localparam int REPORT_CAP  = 200;

   typedef struct packed {
      logic                    op;
      logic [VIDX_W-1:0]       slot;
      logic signed [CRD_W-1:0] x;
      logic signed [CRD_W-1:0] y;
      logic                    hold;
   } cmd_word_type;

   logic                    clock;
   logic                    reset;
   logic                    start;
   logic                    busy;
   logic                    req_operation;
   logic [VIDX_W-1:0]       req_vertex_index;
   logic signed [CRD_W-1:0] req_coord_x;
   logic signed [CRD_W-1:0] req_coord_y;
   logic                    rsp_strobe;
   logic                    rsp_inside_res;
   logic                    csr_wen;
   logic [CSR_IDX_W-1:0]    csr_index;
   logic [CSR_DATA_W-1:0]   csr_wdata;

   cmd_word_type pending_words[$];
   logic         expected_inside[$];

   logic signed [CRD_W-1:0] poly_x [MAX_SLOTS];
   logic signed [CRD_W-1:0] poly_y [MAX_SLOTS];
   logic [VCNT_W-1:0]       poly_count;
   logic                    poly_open;

   logic signed [CRD_W-1:0] shape_x [MAX_SLOTS];
   logic signed [CRD_W-1:0] shape_y [MAX_SLOTS];
   int cen_x, cen_y, spread;

   int idle_pct;
   int words_queued;
   int mismatches;
   int loads_taken;
   int queries_taken;
   int inside_seen;
   int csr_writes;
   int stall_cycles;

   point_in_polygon_test_core i_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_operation    (req_operation),
      .req_vertex_index (req_vertex_index),
      .req_coord_x      (req_coord_x),
      .req_coord_y      (req_coord_y),
      .rsp_strobe       (rsp_strobe),
      .rsp_inside_res   (rsp_inside_res),
      .csr_wen          (csr_wen),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   function automatic logic predict_inside(input logic signed [CRD_W-1:0] qx,
                                           input logic signed [CRD_W-1:0] qy);
      int     n, k, first, crossings;
      longint px, py, lo, hi, far, d1, d2, ea, eb, x1, y1, x2, y2, c1, c2;
      if (poly_open) return 1'b0;
      n = (int'(poly_count) > MAX_SLOTS) ? MAX_SLOTS : int'(poly_count);
      if (n == 0) return 1'b0;
      px = longint'(qx);
      py = longint'(qy);
      lo = longint'(poly_x[0]);
      hi = lo;
      for (k = 1; k < n; k++) begin
         if (longint'(poly_x[k]) < lo) lo = longint'(poly_x[k]);
         if (longint'(poly_x[k]) > hi) hi = longint'(poly_x[k]);
      end
      far = (hi + 1) + (hi + 1 - lo);
      crossings = 0;
      k = 0;
      while (k < n) begin
         d1 = longint'(poly_y[k]) - py;
         if (d1 == 0) begin
            k++;
            continue;
         end
         first = k;
         d2 = longint'(poly_y[(k + 1) % n]) - py;
         while (d2 == 0) begin
            k++;
            d2 = longint'(poly_y[(k + 1) % n]) - py;
         end
         if (first != k) begin
            ea = longint'(poly_x[(first + 1) % n]) - px;
            eb = longint'(poly_x[k % n]) - px;
            if (ea * eb <= 0) return 1'b1;
         end
         if ((d1 < 0 && d2 > 0) || (d1 > 0 && d2 < 0)) begin
            x1 = longint'(poly_x[k % n]);
            y1 = longint'(poly_y[k % n]);
            x2 = longint'(poly_x[(k + 1) % n]);
            y2 = longint'(poly_y[(k + 1) % n]);
            c1 = (px - x1) * (y2 - y1) - (py - y1) * (x2 - x1);
            c2 = (far - x1) * (y2 - y1) - (py - y1) * (x2 - x1);
            if (c1 == 0 || c2 == 0) return 1'b1;
            if ((c1 < 0) != (c2 < 0)) crossings++;
         end
         k++;
      end
      return crossings[0];
   endfunction

   task automatic report_mismatch(input string what);
      mismatches++;
      if (mismatches <= REPORT_CAP) $display("MISMATCH at %0t: %s", $time, what);
   endtask

   // Feed words from the pending queue, holding each one until it is taken.
   always @(posedge clock) begin : word_driver
      logic         go;
      cmd_word_type w;
      if (reset) begin
         start <= 1'b0;
      end else if (!(start && busy)) begin
         go = pending_words.size() != 0 && $urandom_range(99) >= idle_pct;
         if (go && pending_words[0].hold)
            go = expected_inside.size() == 0 && !busy && !rsp_strobe
                 && !(start && req_operation == OPERATION_QUERY);
         if (go) begin
            w = pending_words.pop_front();
            req_operation    <= w.op;
            req_vertex_index <= w.slot;
            req_coord_x      <= w.x;
            req_coord_y      <= w.y;
         end
         start <= go;
      end
   end

   always @(posedge clock) begin : word_monitor
      logic want;
      if (!reset) begin
         if (csr_wen) begin
            csr_writes++;
            case (csr_index)
               CSR_VERTEX_COUNT: poly_count = csr_wdata[VCNT_W-1:0];
               CSR_IS_OPEN:      poly_open  = csr_wdata[0];
               default:          ;
            endcase
         end
         if (rsp_strobe) begin
            if (rsp_inside_res === 1'b1) inside_seen++;
            if (expected_inside.size() == 0) begin
               report_mismatch("answer with no query outstanding");
            end else begin
               want = expected_inside.pop_front();
               if (rsp_inside_res !== want)
                  report_mismatch($sformatf("inside_res got %b, want %b",
                                            rsp_inside_res, want));
            end
         end
         if (start && !busy) begin
            if (req_operation == OPERATION_LOAD) begin
               loads_taken++;
               poly_x[req_vertex_index] = req_coord_x;
               poly_y[req_vertex_index] = req_coord_y;
            end else begin
               queries_taken++;
               expected_inside.push_back(predict_inside(req_coord_x, req_coord_y));
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || csr_wen) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   task automatic push_word(input logic op, input logic [VIDX_W-1:0] slot,
                            input logic signed [CRD_W-1:0] x,
                            input logic signed [CRD_W-1:0] y, input logic hold);
      cmd_word_type w;
      w.op   = op;
      w.slot = slot;
      w.x    = x;
      w.y    = y;
      w.hold = hold;
      pending_words.push_back(w);
      words_queued++;
   endtask

   task automatic wait_idle(input int quiet);
      do @(negedge clock);
      while (pending_words.size() != 0 || expected_inside.size() != 0 || start || busy);
      repeat (quiet) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input int val);
      @(posedge clock);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val[CSR_DATA_W-1:0];
      @(posedge clock);
      csr_wen   <= 1'b0;
   endtask

   function automatic logic signed [CRD_W-1:0] pick_coord(input int centre, input int span);
      int v;
      v = centre + int'($urandom_range(2 * span + 1)) - span - 1;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v[CRD_W-1:0];
   endfunction

   // Load a fresh outline into slots below n; repeat rows and columns to build flat runs.
   task automatic load_shape(input int n);
      int                      k;
      logic signed [CRD_W-1:0] x, y;
      case ($urandom_range(2))
         0: spread = 8;
         1: spread = 300;
         default: spread = 32767;
      endcase
      cen_x = (spread == 32767) ? 0 : int'($urandom_range(60000)) - 30000;
      cen_y = (spread == 32767) ? 0 : int'($urandom_range(60000)) - 30000;
      for (k = 0; k < n; k++) begin
         x = pick_coord(cen_x, spread);
         y = pick_coord(cen_y, spread);
         if (k > 0) begin
            case ($urandom_range(4))
               0: y = shape_y[k-1];
               1: x = shape_x[k-1];
               default: ;
            endcase
         end
         shape_x[k] = x;
         shape_y[k] = y;
         push_word(OPERATION_LOAD, k[VIDX_W-1:0], x, y, 1'b0);
      end
   endtask

   task automatic push_query(input int m);
      int                      pick, u, v;
      logic signed [CRD_W-1:0] qx, qy;
      logic [VIDX_W-1:0]       s;
      pick = (m == 0) ? ($urandom_range(1) ? 0 : 8) : $urandom_range(9);
      u = (m == 0) ? 0 : $urandom_range(m - 1);
      v = (m == 0) ? 0 : $urandom_range(m - 1);
      qx = pick_coord(cen_x, spread);
      qy = pick_coord(cen_y, spread);
      case (pick)
         0, 1, 2: ;
         3, 4: qy = shape_y[v];
         5: begin
            qx = shape_x[v];
            qy = shape_y[v];
         end
         6: qx = shape_x[v];
         7: begin
            qx = shape_x[u];
            qy = shape_y[v];
         end
         8: begin
            qx = CRD_W'($urandom);
            qy = CRD_W'($urandom);
         end
         default: begin
            s = VIDX_W'($urandom);
            shape_x[s] = qx;
            shape_y[s] = qy;
            push_word(OPERATION_LOAD, s, qx, qy, 1'b0);
            return;
         end
      endcase
      push_word(OPERATION_QUERY, VIDX_W'($urandom), qx, qy, $urandom_range(29) == 0);
   endtask

   initial begin : stimulus
      int mode, phase, cnt, n_load, open_flag, q, nq, goal;
      reset            = 1'b1;
      start            = 1'b0;
      req_operation    = OPERATION_LOAD;
      req_vertex_index = '0;
      req_coord_x      = '0;
      req_coord_y      = '0;
      csr_wen          = 1'b0;
      csr_index        = CSR_VERTEX_COUNT;
      csr_wdata        = '0;
      poly_count       = '0;
      poly_open        = 1'b0;
      idle_pct         = 19;
      words_queued     = 0;
      mismatches       = 0;
      loads_taken      = 0;
      queries_taken    = 0;
      inside_seen      = 0;
      csr_writes       = 0;
      stall_cycles     = 0;
      cen_x            = 0;
      cen_y            = 0;
      spread           = 32767;
      for (q = 0; q < MAX_SLOTS; q++) begin
         poly_x[q]  = '0;
         poly_y[q]  = '0;
         shape_x[q] = '0;
         shape_y[q] = '0;
      end
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // empty store answers outside, then a square spanning the whole coordinate range
      push_word(OPERATION_QUERY, 4'hF, CRD_MAX, CRD_MIN, 1'b0);
      push_word(OPERATION_LOAD, 4'd0, CRD_MIN, CRD_MIN, 1'b0);
      push_word(OPERATION_LOAD, 4'd1, CRD_MAX, CRD_MIN, 1'b0);
      push_word(OPERATION_LOAD, 4'd2, CRD_MAX, CRD_MAX, 1'b0);
      push_word(OPERATION_LOAD, 4'd3, CRD_MIN, CRD_MAX, 1'b0);
      wait_idle(4);
      write_reg(CSR_VERTEX_COUNT, 4);
      push_word(OPERATION_QUERY, 4'd0, CRD_MIN, CRD_MIN, 1'b0);
      push_word(OPERATION_QUERY, 4'd5, 16'sd0, 16'sd0, 1'b1);
      push_word(OPERATION_QUERY, 4'd9, CRD_MAX, 16'sd100, 1'b0);
      push_word(OPERATION_QUERY, 4'd15, -16'sd1, CRD_MAX, 1'b0);
      wait_idle(4);
      write_reg(CSR_IS_OPEN, 1);
      push_word(OPERATION_QUERY, 4'd0, 16'sd0, 16'sd0, 1'b0);
      wait_idle(4);
      write_reg(CSR_IS_OPEN, 0);
      // hexagon with a flat run along its bottom row
      push_word(OPERATION_LOAD, 4'd0, 16'sd0, 16'sd0, 1'b0);
      push_word(OPERATION_LOAD, 4'd1, 16'sd10, 16'sd0, 1'b0);
      push_word(OPERATION_LOAD, 4'd2, 16'sd20, 16'sd0, 1'b0);
      push_word(OPERATION_LOAD, 4'd3, 16'sd20, 16'sd10, 1'b0);
      push_word(OPERATION_LOAD, 4'd4, 16'sd10, 16'sd20, 1'b0);
      push_word(OPERATION_LOAD, 4'd5, 16'sd0, 16'sd10, 1'b0);
      push_word(OPERATION_LOAD, 4'd15, -16'sd1, -16'sd1, 1'b0);
      wait_idle(4);
      write_reg(CSR_VERTEX_COUNT, 6);
      push_word(OPERATION_QUERY, 4'd1, 16'sd5, 16'sd0, 1'b0);
      push_word(OPERATION_QUERY, 4'd2, 16'sd30, 16'sd0, 1'b0);
      push_word(OPERATION_QUERY, 4'd3, 16'sd10, 16'sd10, 1'b0);
      push_word(OPERATION_QUERY, 4'd4, -16'sd5, 16'sd10, 1'b0);
      push_word(OPERATION_QUERY, 4'd6, 16'sd25, 16'sd5, 1'b0);

      for (mode = 0; mode < 3; mode++) begin
         idle_pct = (mode == 0) ? 19 : ((mode == 1) ? 46 : 0);
         goal = words_queued + 580;
         phase = 0;
         while (words_queued < goal) begin
            if (phase == 0) begin
               cnt = (mode == 1) ? 31 : 16;
            end else begin
               case ($urandom_range(19))
                  0: cnt = 0;
                  1: cnt = 1;
                  2: cnt = 2;
                  3: cnt = 16;
                  4: cnt = $urandom_range(17, 31);
                  default: cnt = $urandom_range(3, 8);
               endcase
            end
            n_load = (cnt > MAX_SLOTS) ? MAX_SLOTS : cnt;
            open_flag = int'($urandom_range(7) == 0);
            load_shape(n_load);
            wait_idle(4);
            write_reg(CSR_VERTEX_COUNT, cnt);
            write_reg(CSR_IS_OPEN, open_flag);
            nq = $urandom_range(15, 35);
            for (q = 0; q < nq; q++) push_query(n_load);
            phase++;
         end
      end

      wait_idle(300);
      $display("Run took %0d words: %0d vertex loads, %0d point queries, %0d answered inside.",
               loads_taken + queries_taken, loads_taken, queries_taken, inside_seen);
      $display("Register writes: %0d, with sender idle rates of 19, 46 and 0 percent.",
               csr_writes);
      if (mismatches == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
